// ===== hw/rtl/twp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the transfer wave packer.
package twp_pkg;

    // Default rank count, field and register widths.
    localparam int RANK_COUNT_DEF = 64;
    localparam int RANK_BITS      = 6;
    localparam int WAVE_BITS      = 15;
    localparam int TOTAL_BITS     = 16;
    localparam int SESSION_BITS   = 16;
    localparam int BYTE_BITS      = 32;
    localparam int WAVE_LIM_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Hard ceiling on the wave count of one plan.
    localparam logic [WAVE_LIM_BITS-1:0] WAVE_CAP = 16'd32768;

    // Register values after reset.
    localparam logic [SESSION_BITS-1:0]  SESSION_LIMIT_RST      = 16'd4;
    localparam logic [BYTE_BITS-1:0]     RECEIVE_BYTE_LIMIT_RST = 32'd1048576;
    localparam logic [WAVE_LIM_BITS-1:0] WAVE_LIMIT_RST         = 16'd32768;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_LARGE  = 3'd1,
        ST_WAVE_LIMIT = 3'd2,
        ST_BAD_PAIR   = 3'd3,
        ST_ABORTED    = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SESSION_LIMIT      = 2'd0,
        CFG_RECEIVE_BYTE_LIMIT = 2'd1,
        CFG_WAVE_LIMIT         = 2'd2
    } cfg_index_t;

    // Per-rank counters of the current wave.
    typedef struct packed {
        logic [SESSION_BITS-1:0] sessions;
        logic [BYTE_BITS-1:0]    bytes;
    } rank_rec_t;

    // Update of the rank store caused by one flow.
    typedef struct packed {
        logic                 en;
        logic                 clr;
        logic [RANK_BITS-1:0] from_rank;
        rank_rec_t            src_rec;
        logic [RANK_BITS-1:0] to_rank;
        rank_rec_t            dst_rec;
    } rank_wr_t;

endpackage

// ===== hw/rtl/twp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module twp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; a read at the written address returns old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/twp_rank_store.sv =====
`timescale 1ns / 1ps
// Per-rank counter store with two write and two read ports, built from four RAM banks.
module twp_rank_store #(
    parameter int RANK_COUNT = twp_pkg::RANK_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [twp_pkg::RANK_BITS-1:0] rd_from_rank,
    input  logic [twp_pkg::RANK_BITS-1:0] rd_to_rank,
    input  logic [twp_pkg::RANK_BITS-1:0] look_from_rank,
    input  logic [twp_pkg::RANK_BITS-1:0] look_to_rank,
    input  twp_pkg::rank_wr_t             wr,
    output twp_pkg::rank_rec_t            src_live,
    output twp_pkg::rank_rec_t            dst_live
);

    import twp_pkg::*;

    localparam int RANK_SPACE = 2 ** RANK_BITS;
    localparam int RANK_DEPTH = (RANK_COUNT < RANK_SPACE) ? RANK_COUNT : RANK_SPACE;
    localparam int IDX_BITS   = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1;
    localparam int REC_BITS   = $bits(rank_rec_t);

    logic [RANK_DEPTH-1:0] live_reg;
    logic [RANK_DEPTH-1:0] live_next;
    logic [RANK_DEPTH-1:0] bank_reg;
    logic [RANK_DEPTH-1:0] bank_next;
    rank_wr_t              byp_reg;

    logic [IDX_BITS-1:0] wr_src_idx;
    logic [IDX_BITS-1:0] wr_dst_idx;
    logic [IDX_BITS-1:0] rd_src_idx;
    logic [IDX_BITS-1:0] rd_dst_idx;
    logic [IDX_BITS-1:0] look_src_idx;
    logic [IDX_BITS-1:0] look_dst_idx;

    logic [REC_BITS-1:0] a_src_data;
    logic [REC_BITS-1:0] a_dst_data;
    logic [REC_BITS-1:0] b_src_data;
    logic [REC_BITS-1:0] b_dst_data;

    assign wr_src_idx   = wr.from_rank[IDX_BITS-1:0];
    assign wr_dst_idx   = wr.to_rank[IDX_BITS-1:0];
    assign rd_src_idx   = rd_from_rank[IDX_BITS-1:0];
    assign rd_dst_idx   = rd_to_rank[IDX_BITS-1:0];
    assign look_src_idx = look_from_rank[IDX_BITS-1:0];
    assign look_dst_idx = look_to_rank[IDX_BITS-1:0];

    // Bank A takes source-side writes, bank B destination-side writes; each is copied per read port.
    twp_ram #(.WIDTH(REC_BITS), .DEPTH(RANK_DEPTH)) u_ram_a_src (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr_src_idx),
        .wr_data (wr.src_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_src_idx),
        .rd_data (a_src_data)
    );

    twp_ram #(.WIDTH(REC_BITS), .DEPTH(RANK_DEPTH)) u_ram_a_dst (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr_src_idx),
        .wr_data (wr.src_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_dst_idx),
        .rd_data (a_dst_data)
    );

    twp_ram #(.WIDTH(REC_BITS), .DEPTH(RANK_DEPTH)) u_ram_b_src (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr_dst_idx),
        .wr_data (wr.dst_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_src_idx),
        .rd_data (b_src_data)
    );

    twp_ram #(.WIDTH(REC_BITS), .DEPTH(RANK_DEPTH)) u_ram_b_dst (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr_dst_idx),
        .wr_data (wr.dst_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_dst_idx),
        .rd_data (b_dst_data)
    );

    // Live bits clear for a new wave or plan; the bank bit records which bank holds the newest copy.
    always_comb
    begin
        live_next = wr.clr ? '0 : live_reg;
        bank_next = bank_reg;
        if (wr.en)
        begin
            live_next[wr_src_idx] = 1'b1;
            live_next[wr_dst_idx] = 1'b1;
            bank_next[wr_src_idx] = 1'b0;
            bank_next[wr_dst_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            bank_reg <= '0;
        end
        else
        begin
            live_reg <= live_next;
            bank_reg <= bank_next;
        end
    end

    // Capture the write that lands on the same edge as a read, since the RAMs return old data then.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= '0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr;
        end
    end

    // Source-side lookup: dead rank reads zero, then the bypass, then the newest bank.
    always_comb
    begin
        if (!live_reg[look_src_idx])
        begin
            src_live = '0;
        end
        else if (byp_reg.en && (byp_reg.from_rank == look_from_rank))
        begin
            src_live = byp_reg.src_rec;
        end
        else if (byp_reg.en && (byp_reg.to_rank == look_from_rank))
        begin
            src_live = byp_reg.dst_rec;
        end
        else if (bank_reg[look_src_idx])
        begin
            src_live = b_src_data;
        end
        else
        begin
            src_live = a_src_data;
        end
    end

    // Destination-side lookup, same order.
    always_comb
    begin
        if (!live_reg[look_dst_idx])
        begin
            dst_live = '0;
        end
        else if (byp_reg.en && (byp_reg.from_rank == look_to_rank))
        begin
            dst_live = byp_reg.src_rec;
        end
        else if (byp_reg.en && (byp_reg.to_rank == look_to_rank))
        begin
            dst_live = byp_reg.dst_rec;
        end
        else if (bank_reg[look_dst_idx])
        begin
            dst_live = b_dst_data;
        end
        else
        begin
            dst_live = a_dst_data;
        end
    end

    // The two ranks written by one flow are always distinct.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (wr.from_rank != wr.to_rank))
        else $error("rank store written twice at one rank");

endmodule

// ===== hw/rtl/transfer_wave_packer.sv =====
`timescale 1ns / 1ps
// Path: an accepted flow is registered in the compute stage and then in the result register; the
// rank read registers on the input transfer edge itself.
// Throughput: one flow per cycle unless stalled; the rank store serves two reads and two writes
// each cycle. A stalled result holds the next flow in the compute stage and stalls the input.
// Reset: registers return to their defaults, the plan (wave, error, rank counters) is cleared at
// once through per-rank live bits, and both channels are empty; no clearing pass is needed.
module transfer_wave_packer #(
    parameter int RANK_COUNT = twp_pkg::RANK_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [twp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [twp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               first_flow,
    input  logic                               last_flow,
    input  logic [twp_pkg::RANK_BITS-1:0]      from_rank,
    input  logic [twp_pkg::RANK_BITS-1:0]      to_rank,
    input  logic [twp_pkg::BYTE_BITS-1:0]      flow_bytes,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [twp_pkg::WAVE_BITS-1:0]      wave_number,
    output logic                               opened_wave,
    output logic [2:0]                         status,
    output logic [twp_pkg::TOTAL_BITS-1:0]     total_waves,
    output logic                               plan_done
);

    import twp_pkg::*;

    localparam int RANK_CMP_BITS = 17;
    localparam logic [RANK_CMP_BITS-1:0] RANK_LIMIT = RANK_CMP_BITS'(RANK_COUNT);

    // Configuration registers.
    logic [SESSION_BITS-1:0]  session_limit_reg;
    logic [BYTE_BITS-1:0]     receive_byte_limit_reg;
    logic [WAVE_LIM_BITS-1:0] wave_limit_reg;

    // Compute stage holding the accepted flow.
    logic                 b_valid_reg;
    logic                 b_first_reg;
    logic                 b_last_reg;
    logic [RANK_BITS-1:0] b_src_reg;
    logic [RANK_BITS-1:0] b_dst_reg;
    logic [BYTE_BITS-1:0] b_bytes_reg;

    // Plan state.
    logic [WAVE_BITS-1:0] current_wave_reg;
    logic [WAVE_BITS-1:0] current_wave_next;
    logic                 wave_used_reg;
    logic                 wave_used_next;
    logic                 error_seen_reg;
    logic                 error_seen_next;

    // Result register.
    logic                  out_valid_reg;
    logic [WAVE_BITS-1:0]  wave_number_reg;
    logic [WAVE_BITS-1:0]  wave_number_next;
    logic                  opened_wave_reg;
    logic                  opened_wave_next;
    status_t               status_reg;
    status_t               status_next;
    logic [TOTAL_BITS-1:0] total_waves_reg;
    logic [TOTAL_BITS-1:0] total_waves_next;
    logic                  plan_done_reg;

    logic in_accept;
    logic b_advance;

    rank_rec_t src_live;
    rank_rec_t dst_live;
    rank_wr_t  rank_wr;

    logic [WAVE_BITS-1:0]     cw;
    logic                     used;
    logic                     err;
    logic [SESSION_BITS-1:0]  src_sess;
    logic [SESSION_BITS-1:0]  dst_sess;
    logic [BYTE_BITS-1:0]     src_got;
    logic [BYTE_BITS-1:0]     dst_got;
    logic [WAVE_LIM_BITS-1:0] wave_cap;
    logic [WAVE_LIM_BITS-1:0] cw_plus1;
    logic [WAVE_LIM_BITS-1:0] cw_plus2;
    logic [BYTE_BITS:0]       dst_sum;
    logic                     bad_pair;
    logic                     fit_cur;
    logic                     fit_fresh;
    logic                     open;
    logic                     flow_ok;
    logic [WAVE_BITS-1:0]     new_wave;

    // Transfer control: the compute stage moves on whenever the result register is free.
    assign b_advance = b_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = b_valid_reg && !b_advance;
    assign in_accept = in_valid && !in_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_limit_reg      <= SESSION_LIMIT_RST;
            receive_byte_limit_reg <= RECEIVE_BYTE_LIMIT_RST;
            wave_limit_reg         <= WAVE_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SESSION_LIMIT:      session_limit_reg      <= cfg_data[SESSION_BITS-1:0];
                CFG_RECEIVE_BYTE_LIMIT: receive_byte_limit_reg <= cfg_data[BYTE_BITS-1:0];
                CFG_WAVE_LIMIT:         wave_limit_reg         <= cfg_data[WAVE_LIM_BITS-1:0];
                default:                ;
            endcase
        end
    end

    // Input register of the compute stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (in_accept || b_advance)
        begin
            b_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            b_first_reg <= first_flow;
            b_last_reg  <= last_flow;
            b_src_reg   <= from_rank;
            b_dst_reg   <= to_rank;
            b_bytes_reg <= flow_bytes;
        end
    end

    // Per-rank counters, read at the input transfer and looked up in the compute stage.
    twp_rank_store #(.RANK_COUNT(RANK_COUNT)) u_rank_store (
        .clk            (clk),
        .rst_n          (rst_n),
        .rd_en          (in_accept),
        .rd_from_rank   (from_rank),
        .rd_to_rank     (to_rank),
        .look_from_rank (b_src_reg),
        .look_to_rank   (b_dst_reg),
        .wr             (rank_wr),
        .src_live       (src_live),
        .dst_live       (dst_live)
    );

    // Plan view of this flow; a first flow sees an empty plan.
    always_comb
    begin
        cw       = b_first_reg ? '0 : current_wave_reg;
        used     = !b_first_reg && wave_used_reg;
        err      = !b_first_reg && error_seen_reg;
        src_sess = b_first_reg ? '0 : src_live.sessions;
        dst_sess = b_first_reg ? '0 : dst_live.sessions;
        src_got  = b_first_reg ? '0 : src_live.bytes;
        dst_got  = b_first_reg ? '0 : dst_live.bytes;
        wave_cap = (wave_limit_reg > WAVE_CAP) ? WAVE_CAP : wave_limit_reg;
        cw_plus1 = {1'b0, cw} + WAVE_LIM_BITS'(1);
        cw_plus2 = {1'b0, cw} + WAVE_LIM_BITS'(2);
        dst_sum  = {1'b0, dst_got} + {1'b0, b_bytes_reg};
    end

    // Fit checks in the current wave and in a fresh one.
    always_comb
    begin
        bad_pair  = (b_src_reg == b_dst_reg)
                 || (RANK_CMP_BITS'(b_src_reg) >= RANK_LIMIT)
                 || (RANK_CMP_BITS'(b_dst_reg) >= RANK_LIMIT);
        fit_cur   = (src_sess < session_limit_reg) && (dst_sess < session_limit_reg)
                 && (dst_sum <= {1'b0, receive_byte_limit_reg});
        fit_fresh = (session_limit_reg != '0) && (b_bytes_reg <= receive_byte_limit_reg);
    end

    // Placement decision.
    always_comb
    begin
        open        = 1'b0;
        status_next = ST_OK;
        if (err)
        begin
            status_next = ST_ABORTED;
        end
        else if (bad_pair)
        begin
            status_next = ST_BAD_PAIR;
        end
        else if (cw_plus1 > wave_cap)
        begin
            status_next = ST_WAVE_LIMIT;
        end
        else if (!fit_cur)
        begin
            if (!used)
            begin
                status_next = ST_TOO_LARGE;
            end
            else if (cw_plus2 > wave_cap)
            begin
                status_next = ST_WAVE_LIMIT;
            end
            else if (!fit_fresh)
            begin
                status_next = ST_TOO_LARGE;
            end
            else
            begin
                open = 1'b1;
            end
        end
        flow_ok  = (status_next == ST_OK);
        new_wave = open ? (cw + WAVE_BITS'(1)) : cw;
    end

    // Next plan state, result fields and rank store update.
    always_comb
    begin
        current_wave_next = flow_ok ? new_wave : cw;
        wave_used_next    = flow_ok || used;
        error_seen_next   = !flow_ok;

        wave_number_next  = flow_ok ? new_wave : '0;
        opened_wave_next  = flow_ok && open;
        total_waves_next  = flow_ok ? ({1'b0, new_wave} + TOTAL_BITS'(1)) : '0;

        rank_wr.en               = b_advance && flow_ok;
        rank_wr.clr              = b_advance && (b_first_reg || open);
        rank_wr.from_rank        = b_src_reg;
        rank_wr.to_rank          = b_dst_reg;
        rank_wr.src_rec.sessions = (open ? '0 : src_sess) + SESSION_BITS'(1);
        rank_wr.src_rec.bytes    = open ? '0 : src_got;
        rank_wr.dst_rec.sessions = (open ? '0 : dst_sess) + SESSION_BITS'(1);
        rank_wr.dst_rec.bytes    = open ? b_bytes_reg : dst_sum[BYTE_BITS-1:0];
    end

    // Plan state registers, updated as the flow leaves the compute stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_wave_reg <= '0;
            wave_used_reg    <= 1'b0;
            error_seen_reg   <= 1'b0;
        end
        else if (b_advance)
        begin
            current_wave_reg <= current_wave_next;
            wave_used_reg    <= wave_used_next;
            error_seen_reg   <= error_seen_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= b_advance || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_advance)
        begin
            wave_number_reg <= wave_number_next;
            opened_wave_reg <= opened_wave_next;
            status_reg      <= status_next;
            total_waves_reg <= total_waves_next;
            plan_done_reg   <= b_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign wave_number = wave_number_reg;
    assign opened_wave = opened_wave_reg;
    assign status      = status_reg;
    assign total_waves = total_waves_reg;
    assign plan_done   = plan_done_reg;

    // The input side is held back only while a flow waits in the compute stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> b_valid_reg)
        else $error("input stalled with an empty compute stage");

    // A failed flow reports no placement.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg != ST_OK))
            |-> ((wave_number == '0) && (total_waves == '0) && !opened_wave))
        else $error("failed flow carries placement fields");

    // A placed flow reports a wave count one above its wave.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg == ST_OK))
            |-> (total_waves == ({1'b0, wave_number} + TOTAL_BITS'(1))))
        else $error("wave count does not match placed wave");

    // An error holds until a flow starts a new plan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (error_seen_reg && !(b_advance && b_first_reg)) |=> error_seen_reg)
        else $error("sticky error dropped without a new plan");

    // Within a plan the current wave never moves back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_advance && !b_first_reg) |=> (current_wave_reg >= $past(current_wave_reg)))
        else $error("current wave decreased within a plan");

endmodule
